/* hdl/r2h_pkg.sv */
// Shared constants, types and the divider step for the RGB to HSV converter.
package r2h_pkg;

  localparam int unsigned CHANNEL_BITS      = 8;
  localparam int unsigned HUE_FRACTION_BITS = 6;

  localparam logic [CHANNEL_BITS-1:0] CHAN_MAX = '1;

  localparam int unsigned HUE_SIXTY = 60 << HUE_FRACTION_BITS;
  localparam int unsigned HUE_FULL  = 360 << HUE_FRACTION_BITS;

  // hue result width, and one more bit for signed intermediate sums
  localparam int unsigned HUE_W  = $clog2(HUE_FULL);
  localparam int unsigned HUE_SW = HUE_W + 1;

  // hue quotient is at most HUE_SIXTY, saturation quotient at most CHAN_MAX
  localparam int unsigned HQ_W = $clog2(HUE_SIXTY + 1);
  localparam int unsigned NH_W = CHANNEL_BITS + HQ_W;
  localparam int unsigned NS_W = 2 * CHANNEL_BITS;

  localparam int unsigned DIV_STAGES = (HQ_W > CHANNEL_BITS) ? HQ_W : CHANNEL_BITS;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  // front end result: channel statistics of one pixel
  typedef struct packed {
    logic [CHANNEL_BITS-1:0] mx;
    logic [CHANNEL_BITS-1:0] delta;
    logic [CHANNEL_BITS-1:0] absdiff;
    logic                    neg;
    sector_e                 sector;
  } r2h_front_t;

  // divider pipeline stage contents
  typedef struct packed {
    logic [NH_W-1:0]         rem_h;
    logic [NS_W-1:0]         rem_s;
    logic [CHANNEL_BITS-1:0] delta;
    logic [CHANNEL_BITS-1:0] mx;
    logic [HQ_W-1:0]         q_h;
    logic [CHANNEL_BITS-1:0] q_s;
    logic                    neg;
    sector_e                 sector;
  } r2h_dstage_t;

  // One restoring step: resolve quotient bit k of both divisions.
  function automatic r2h_dstage_t div_step(r2h_dstage_t s, int unsigned k);
    r2h_dstage_t     n;
    logic [NH_W-1:0] dh;
    logic [NS_W-1:0] ds;
    n  = s;
    dh = NH_W'(s.delta) << k;
    ds = NS_W'(s.mx) << k;
    if (k < HQ_W) begin
      if (s.rem_h >= dh) begin
        n.rem_h  = s.rem_h - dh;
        n.q_h[k] = 1'b1;
      end
    end
    if (k < CHANNEL_BITS) begin
      if (s.rem_s >= ds) begin
        n.rem_s  = s.rem_s - ds;
        n.q_s[k] = 1'b1;
      end
    end
    return n;
  endfunction

endpackage

/* hdl/r2h_div.sv */
// Pipelined restoring divider: hue offset and saturation, one quotient bit per stage.
module r2h_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  r2h_pkg::r2h_front_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output r2h_pkg::r2h_dstage_t out_data_o
);

  localparam int unsigned Stages = r2h_pkg::DIV_STAGES;

  r2h_pkg::r2h_dstage_t init;
  r2h_pkg::r2h_dstage_t src  [Stages];
  r2h_pkg::r2h_dstage_t st_q [Stages];
  logic                 src_v [Stages];
  logic                 v_q   [Stages];
  logic [Stages:0]      rdy;

  // numerators are constant multiples: 60-degree span times |diff|, full scale times delta
  always_comb begin
    init        = '0;
    init.rem_h  = r2h_pkg::NH_W'(in_data_i.absdiff) * r2h_pkg::NH_W'(r2h_pkg::HUE_SIXTY);
    init.rem_s  = r2h_pkg::NS_W'(in_data_i.delta) * r2h_pkg::NS_W'(r2h_pkg::CHAN_MAX);
    init.delta  = in_data_i.delta;
    init.mx     = in_data_i.mx;
    init.neg    = in_data_i.neg;
    init.sector = in_data_i.sector;
  end

  assign rdy[Stages] = out_ready_i;

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    if (i == 0) begin : g_first
      assign src[i]   = init;
      assign src_v[i] = in_valid_i;
    end else begin : g_next
      assign src[i]   = st_q[i-1];
      assign src_v[i] = v_q[i-1];
    end

    // a stage takes new data when empty or when its contents move on
    assign rdy[i] = !v_q[i] || rdy[i+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_q[i] <= src_v[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[i] && src_v[i]) begin
        st_q[i] <= r2h_pkg::div_step(src[i], Stages - 1 - i);
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[Stages-1];
  assign out_data_o  = st_q[Stages-1];

endmodule

/* hdl/rgb_to_hsv.sv */
// RGB to HSV converter top level: channel statistics, divider pipeline, hue fixup.
// Pipeline: each result passes through the front stage register, the 12 divider stages and
// the output register in turn; the divider depth follows the hue quotient width.
// Throughput: one pixel per cycle; stalls propagate stage by stage and empty stages fill.
// Reset: rst_ni clears all valid bits asynchronously; payload registers are not reset.
module rgb_to_hsv (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [r2h_pkg::CHANNEL_BITS-1:0]    red_i,
  input  logic [r2h_pkg::CHANNEL_BITS-1:0]    green_i,
  input  logic [r2h_pkg::CHANNEL_BITS-1:0]    blue_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [r2h_pkg::HUE_W-1:0]           hue_o,
  output logic [r2h_pkg::CHANNEL_BITS-1:0]    saturation_o,
  output logic [r2h_pkg::CHANNEL_BITS-1:0]    brightness_o
);

  localparam int unsigned CW  = r2h_pkg::CHANNEL_BITS;
  localparam int unsigned HSW = r2h_pkg::HUE_SW;
  localparam logic signed [HSW-1:0] HueFullS  = HSW'(r2h_pkg::HUE_FULL);
  localparam logic signed [HSW-1:0] HueSixtyS = HSW'(r2h_pkg::HUE_SIXTY);

  // ---------------- front stage: max, min, sector, difference
  logic [CW-1:0]        mx, mn, dp, dn;
  r2h_pkg::r2h_front_t  front_d, front_q;
  logic                 a_v_q, a_rdy;
  logic                 div_in_ready;

  always_comb begin
    mx = red_i;
    mn = red_i;
    if (green_i > mx) mx = green_i;
    if (blue_i > mx) mx = blue_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;

    front_d       = '0;
    front_d.mx    = mx;
    front_d.delta = mx - mn;
    // ties: red beats green, green beats blue
    if (mx == red_i) begin
      front_d.sector = r2h_pkg::SECT_RED;
      dp = green_i;
      dn = blue_i;
    end else if (mx == green_i) begin
      front_d.sector = r2h_pkg::SECT_GREEN;
      dp = blue_i;
      dn = red_i;
    end else begin
      front_d.sector = r2h_pkg::SECT_BLUE;
      dp = red_i;
      dn = green_i;
    end
    front_d.neg     = dp < dn;
    front_d.absdiff = (dp < dn) ? (dn - dp) : (dp - dn);
  end

  assign a_rdy      = !a_v_q || div_in_ready;
  assign in_ready_o = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (a_rdy) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_valid_i) begin
      front_q <= front_d;
    end
  end

  // ---------------- divider pipeline
  r2h_pkg::r2h_dstage_t div_out;
  logic                 div_v;
  logic                 f_rdy;

  r2h_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (a_v_q),
    .in_ready_o  (div_in_ready),
    .in_data_i   (front_q),
    .out_valid_o (div_v),
    .out_ready_i (f_rdy),
    .out_data_o  (div_out)
  );

  // ---------------- hue assembly and output register
  logic signed [HSW-1:0] base, mag, pos, hsum, hwrap;
  logic [r2h_pkg::HUE_W-1:0] hue_d, hue_q;
  logic [CW-1:0]             sat_d, sat_q, val_q;
  logic                      f_v_q;

  always_comb begin
    case (div_out.sector)
      r2h_pkg::SECT_RED:   base = '0;
      r2h_pkg::SECT_GREEN: base = HueSixtyS <<< 1;
      r2h_pkg::SECT_BLUE:  base = HueSixtyS <<< 2;
      default:             base = '0;
    endcase
    pos = HSW'(div_out.q_h);
    // floor of a negative quotient: round the magnitude up when a remainder is left
    mag = HSW'(div_out.q_h) + HSW'(div_out.rem_h != '0);
    hsum = div_out.neg ? (base - mag) : (base + pos);
    if (hsum < 0) begin
      hwrap = hsum + HueFullS;
    end else if (hsum >= HueFullS) begin
      hwrap = hsum - HueFullS;
    end else begin
      hwrap = hsum;
    end
    hue_d = (div_out.delta == '0) ? '0 : hwrap[r2h_pkg::HUE_W-1:0];
    sat_d = (div_out.mx == '0) ? '0 : div_out.q_s;
  end

  assign f_rdy = !f_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (f_rdy) begin
      f_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_rdy && div_v) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= div_out.mx;
    end
  end

  assign out_valid_o  = f_v_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = val_q;

  // ---------------- assertions
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (hue_o < r2h_pkg::HUE_W'(r2h_pkg::HUE_FULL)))
    else $error("hue out of range");

  a_black_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && brightness_o == '0) |-> (saturation_o == '0 && hue_o == '0))
    else $error("black pixel with nonzero saturation or hue");

  a_hue_needs_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hue_o != '0) |-> (saturation_o != '0))
    else $error("colored hue with zero saturation");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output register is empty");

endmodule
